### rtl/erfc_pkg.sv
// Package for the encoder reply frame checker.
// Holds the frame constants and the structs passed between the checker modules.
// Depends on nothing.
package erfc_pkg;

  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned CNT_W = $clog2(FRAME_LEN + 1);
  localparam int unsigned IDX_W = $clog2(FRAME_LEN);
  localparam logic [15:0] RATE_FULL = 16'hFFFF;
  localparam logic [15:0] COEFF_RESET = 16'd13;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END = 1'b1;

  typedef struct packed {
    logic       wr;
    logic       fin;
    logic [7:0] data;
  } erfc_evt_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  status;
    logic [23:0] position;
    logic [23:0] multiturn;
    logic [7:0]  alarm;
  } erfc_frame_t;

endpackage

### rtl/encoder_reply_frame_checker_unit.sv
// Top level of the encoder reply frame checker: input register, result register, stored values.
// Depends on erfc_pkg, erfc_frame_acc and erfc_rate_filter.
//
// Channel | Direction | Contents
// in_     | slave     | tdata: rx_byte[7:0]; tuser: action (0 byte, 1 end of reply)
// out_    | master    | tdata: position, multiturn, status_flags, alarm_byte, error_count,
//         |           |        error_rate (lowest first); tuser: frame_ok
// cfg_    | write     | cfg_wr_data: rate_filter_coeff
//
// One transaction per cycle is accepted unless the input stalls; a reply byte produces no result.
// An end-of-reply transaction gives its result through the input register, then the result
// register. The filter multiply sits between those two registers.
// Reset clears counters, stored values and valid flags; the coefficient returns to 13.
// A stalled result stalls the input only while an end-of-reply transaction waits in the
// input register.
module encoder_reply_frame_checker_unit
  import erfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // rx_byte[7:0]
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // position, multiturn, status_flags, alarm_byte,
                                   // error_count, error_rate
  output logic         out_tuser,  // frame_ok
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  logic        in_valid_r;
  logic        in_action_r;
  logic [7:0]  in_byte_r;
  logic        advance;
  logic        load;
  erfc_evt_t   evt;
  erfc_frame_t frame;
  logic [15:0] coeff_r;
  logic [15:0] rate;
  logic [15:0] rate_nxt;
  logic [23:0] pos_r;
  logic [23:0] turns_r;
  logic [7:0]  status_r;
  logic [7:0]  alarm_r;
  logic [31:0] err_cnt_r;
  logic [23:0] pos_nxt;
  logic [23:0] turns_nxt;
  logic [7:0]  status_nxt;
  logic [7:0]  alarm_nxt;
  logic [31:0] err_cnt_nxt;
  logic        out_valid_r;
  logic        out_ok_r;
  logic [111:0] out_data_r;

  assign advance   = !(in_valid_r && (in_action_r == ACT_END) && out_valid_r && !out_tready);
  assign in_tready = !in_valid_r || advance;
  assign load      = in_valid_r && (in_action_r == ACT_END) && advance;

  always_comb begin
    evt.wr   = in_valid_r && advance && (in_action_r == ACT_BYTE);
    evt.fin  = load;
    evt.data = in_byte_r;
  end

  erfc_frame_acc u_frame_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .frame (frame)
  );

  erfc_rate_filter u_rate_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .fin      (load),
    .ok       (frame.ok),
    .coeff    (coeff_r),
    .rate     (rate),
    .rate_nxt (rate_nxt)
  );

  always_comb begin
    pos_nxt     = pos_r;
    turns_nxt   = turns_r;
    status_nxt  = status_r;
    alarm_nxt   = alarm_r;
    err_cnt_nxt = err_cnt_r;
    if (load) begin
      if (frame.ok) begin
        pos_nxt    = frame.position;
        turns_nxt  = frame.multiturn;
        status_nxt = frame.status;
        alarm_nxt  = frame.alarm;
      end else begin
        err_cnt_nxt = err_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      coeff_r     <= COEFF_RESET;
      pos_r       <= '0;
      turns_r     <= '0;
      status_r    <= '0;
      alarm_r     <= '0;
      err_cnt_r   <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        coeff_r <= cfg_wr_data;
      end
      pos_r     <= pos_nxt;
      turns_r   <= turns_nxt;
      status_r  <= status_nxt;
      alarm_r   <= alarm_nxt;
      err_cnt_r <= err_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_action_r <= in_tuser;
      in_byte_r   <= in_tdata;
    end
    if (load) begin
      out_ok_r   <= frame.ok;
      out_data_r <= {rate_nxt, err_cnt_nxt, alarm_nxt, status_nxt, turns_nxt, pos_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_data_r;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_good_lowers_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (load && frame.ok) |-> (rate_nxt <= rate))
    else $error("good reply raised the error rate");

  a_bad_raises_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !frame.ok) |-> (rate_nxt >= rate) && (err_cnt_nxt != err_cnt_r))
    else $error("bad reply did not raise rate or count");

  a_stall_only_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

endmodule

### rtl/erfc_frame_acc.sv
// Reply byte collector: stores the reply bytes, counts them and keeps a running XOR.
// Depends on erfc_pkg.
module erfc_frame_acc
  import erfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  erfc_evt_t   evt,
  output erfc_frame_t frame
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [7:0]       xor_r;
  logic [7:0]       xor_nxt;
  logic [7:0]       bytes_r [FRAME_LEN];

  always_comb begin
    count_nxt = count_r;
    xor_nxt   = xor_r;
    if (evt.fin) begin
      count_nxt = '0;
      xor_nxt   = '0;
    end else if (evt.wr && (count_r < CNT_W'(FRAME_LEN))) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r < CNT_W'(FRAME_LEN - 1)) begin
        xor_nxt = xor_r ^ evt.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      xor_r   <= '0;
    end else begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.wr && !evt.fin && (count_r < CNT_W'(FRAME_LEN))) begin
      bytes_r[count_r[IDX_W-1:0]] <= evt.data;
    end
  end

  always_comb begin
    frame.ok        = (count_r == CNT_W'(FRAME_LEN)) && (xor_r == bytes_r[FRAME_LEN-1]);
    frame.status    = bytes_r[1];
    frame.position  = {bytes_r[4], bytes_r[3], bytes_r[2]};
    frame.multiturn = {bytes_r[8], bytes_r[7], bytes_r[6]};
    frame.alarm     = bytes_r[9];
  end

endmodule

### rtl/erfc_rate_filter.sv
// Error-rate low-pass filter, Q0.16, stepping toward zero or full scale per reply.
// Depends on erfc_pkg.
module erfc_rate_filter
  import erfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fin,
  input  logic        ok,
  input  logic [15:0] coeff,
  output logic [15:0] rate,
  output logic [15:0] rate_nxt
);

  logic [15:0] rate_r;
  logic [15:0] gap;
  logic [31:0] prod;
  logic [32:0] rounded;
  logic [16:0] step_raw;
  logic [15:0] step;
  logic [15:0] target;

  always_comb begin
    gap      = ok ? rate_r : (RATE_FULL - rate_r);
    prod     = gap * coeff;
    rounded  = {1'b0, prod} + 33'd65535;
    step_raw = rounded[32:16];
    step     = (step_raw > {1'b0, gap}) ? gap : step_raw[15:0];
    target   = ok ? (rate_r - step) : (rate_r + step);
    rate_nxt = fin ? target : rate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else begin
      rate_r <= rate_nxt;
    end
  end

  assign rate = rate_r;

endmodule

### bench/tb_encoder_reply_frame_checker_unit.sv
// Self-checking testbench for encoder_reply_frame_checker_unit: streams encoder reply bytes and
// end-of-reply events, predicts every result and compares it with the block's result stream.
// Depends on erfc_pkg and the RTL of encoder_reply_frame_checker_unit.
`timescale 1ns / 100ps

module tb_encoder_reply_frame_checker_unit
  import erfc_pkg::*;
();

  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int TARGET_ITEMS = 1550;
  localparam int HOLD_START = 800;
  localparam int HOLD_CYCLES = 300;
  localparam int BURST_START = 1500;
  localparam int BURST_END = 2300;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {SEND_ITEM, WRITE_COEFF, WAIT_IDLE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic        action;
    logic [7:0]  data;
    logic [15:0] coeff;
  } stim_step_t;

  typedef struct {
    logic        frame_ok;
    logic [23:0] position;
    logic [23:0] multiturn;
    logic [7:0]  status_flags;
    logic [7:0]  alarm_byte;
    logic [31:0] error_count;
    logic [15:0] error_rate;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tuser = ACT_BYTE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = 16'h0000;

  stim_step_t pending[$];
  reply_t     reply_queue[$];
  int         mismatches = 0;
  int         cyc = 0;
  int         settle = 0;
  int         hold_left = 0;
  int         item_total = 0;

  logic [7:0]  rx_buf[FRAME_LEN];
  int          rx_count = 0;
  logic [23:0] last_pos = '0;
  logic [23:0] last_turns = '0;
  logic [7:0]  last_status = '0;
  logic [7:0]  last_alarm = '0;
  logic [31:0] bad_count = '0;
  logic [15:0] err_rate = '0;
  logic [15:0] rate_coeff = COEFF_RESET;

  wire no_idle = (cyc >= BURST_START) && (cyc < BURST_END);

  encoder_reply_frame_checker_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [15:0] rate_step(logic [15:0] gap, logic [15:0] k);
    logic [32:0] prod;
    logic [16:0] step;
    prod = gap * k + 33'd65535;
    step = prod[32:16];
    return (step > gap) ? gap : step[15:0];
  endfunction

  function void take_transaction(logic act, logic [7:0] b);
    reply_t     r;
    logic [7:0] sum;
    logic       good;
    int         i;
    if (act == ACT_BYTE) begin
      if (rx_count < FRAME_LEN) begin
        rx_buf[rx_count] = b;
        rx_count++;
      end
      return;
    end
    good = (rx_count == FRAME_LEN);
    if (good) begin
      sum = 8'h00;
      for (i = 0; i < FRAME_LEN - 1; i++) sum ^= rx_buf[i];
      good = (sum == rx_buf[FRAME_LEN - 1]);
    end
    if (good) begin
      last_status = rx_buf[1];
      last_pos = {rx_buf[4], rx_buf[3], rx_buf[2]};
      last_turns = {rx_buf[8], rx_buf[7], rx_buf[6]};
      last_alarm = rx_buf[9];
      err_rate = err_rate - rate_step(err_rate, rate_coeff);
    end else begin
      bad_count = bad_count + 32'd1;
      err_rate = err_rate + rate_step(RATE_FULL - err_rate, rate_coeff);
    end
    rx_count = 0;
    r.frame_ok = good;
    r.position = last_pos;
    r.multiturn = last_turns;
    r.status_flags = last_status;
    r.alarm_byte = last_alarm;
    r.error_count = bad_count;
    r.error_rate = err_rate;
    reply_queue.push_back(r);
  endfunction

  function void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
  endfunction

  function void push_item(logic act, logic [7:0] b);
    stim_step_t s;
    s.kind = SEND_ITEM;
    s.action = act;
    s.data = b;
    s.coeff = '0;
    pending.push_back(s);
    item_total++;
  endfunction

  function void push_marker(step_kind_t kind, logic [15:0] k);
    stim_step_t s;
    s.kind = kind;
    s.action = ACT_BYTE;
    s.data = '0;
    s.coeff = k;
    pending.push_back(s);
  endfunction

  function void push_frame(logic [7:0] fill, bit random_fill, bit break_sum, int extra);
    logic [7:0] b;
    logic [7:0] sum;
    int         i;
    sum = 8'h00;
    for (i = 0; i < FRAME_LEN - 1; i++) begin
      b = random_fill ? 8'($urandom) : fill;
      sum ^= b;
      push_item(ACT_BYTE, b);
    end
    if (break_sum) sum ^= 8'(1 << $urandom_range(7));
    push_item(ACT_BYTE, sum);
    for (i = 0; i < extra; i++) push_item(ACT_BYTE, 8'($urandom));
    push_item(ACT_END, 8'($urandom));
  endfunction

  function void push_random_reply();
    int pick;
    int len;
    int i;
    pick = $urandom_range(99);
    if (pick < 65) begin
      push_frame('0, 1'b1, 1'b0, 0);
    end else if (pick < 75) begin
      push_frame('0, 1'b1, 1'b1, 0);
    end else if (pick < 85) begin
      len = $urandom_range(16);
      if (len == FRAME_LEN) len++;
      for (i = 0; i < len; i++) push_item(ACT_BYTE, 8'($urandom));
      push_item(ACT_END, 8'($urandom));
    end else if (pick < 92) begin
      push_frame('0, 1'b1, 1'($urandom_range(1)), int'($urandom_range(1, 3)));
    end else begin
      len = $urandom_range(1, 5);
      for (i = 0; i < len; i++) push_item(1'($urandom), 8'($urandom));
    end
  endfunction

  // Driver: at most one pending step per cycle, once the current transaction is gone.
  always @(posedge clk) begin : drive
    logic        nv;
    logic [7:0]  nd;
    logic        nu;
    logic        cw;
    logic [15:0] cd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      nv = in_tvalid;
      nd = in_tdata;
      nu = in_tuser;
      cw = 1'b0;
      cd = cfg_wr_data;
      if (!in_tvalid || in_tready) begin
        nv = 1'b0;
        if (pending.size() != 0) begin
          unique case (pending[0].kind)
            SEND_ITEM: begin
              if (no_idle || $urandom_range(99) >= 29) begin
                nv = 1'b1;
                nd = pending[0].data;
                nu = pending[0].action;
                void'(pending.pop_front());
              end
            end
            WRITE_COEFF: begin
              if (settle >= SETTLE_CYCLES) begin
                cw = 1'b1;
                cd = pending[0].coeff;
                void'(pending.pop_front());
              end
            end
            default: begin
              if (settle >= SETTLE_CYCLES) void'(pending.pop_front());
            end
          endcase
        end
      end
      in_tvalid <= nv;
      in_tdata <= nd;
      in_tuser <= nu;
      cfg_wr_en <= cw;
      cfg_wr_data <= cd;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (cyc == HOLD_START) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 29);
    end
  end

  // Monitor: checks each result transaction, then tracks configuration and input transactions.
  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      settle <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_queue.size() == 0) begin
          note_mismatch("unexpected result", '0, out_tdata[31:0]);
        end else begin
          want = reply_queue.pop_front();
          if (out_tuser !== want.frame_ok)
            note_mismatch("frame_ok", 32'(want.frame_ok), 32'(out_tuser));
          if (out_tdata[23:0] !== want.position)
            note_mismatch("position", 32'(want.position), 32'(out_tdata[23:0]));
          if (out_tdata[47:24] !== want.multiturn)
            note_mismatch("multiturn", 32'(want.multiturn), 32'(out_tdata[47:24]));
          if (out_tdata[55:48] !== want.status_flags)
            note_mismatch("status_flags", 32'(want.status_flags), 32'(out_tdata[55:48]));
          if (out_tdata[63:56] !== want.alarm_byte)
            note_mismatch("alarm_byte", 32'(want.alarm_byte), 32'(out_tdata[63:56]));
          if (out_tdata[95:64] !== want.error_count)
            note_mismatch("error_count", want.error_count, out_tdata[95:64]);
          if (out_tdata[111:96] !== want.error_rate)
            note_mismatch("error_rate", 32'(want.error_rate), 32'(out_tdata[111:96]));
        end
      end
      if (cfg_wr_en) rate_coeff = cfg_wr_data;
      if (in_tvalid && in_tready) take_transaction(in_tuser, in_tdata);
      if (in_tvalid || cfg_wr_en || reply_queue.size() != 0) settle <= 0;
      else if (settle < SETTLE_CYCLES) settle <= settle + 1;
    end
  end

  initial begin
    logic [15:0] coeffs[7];
    int          phase;
    int          phase_end;
    coeffs = '{16'd65535, 16'd0, 16'd1, 16'($urandom), COEFF_RESET, 16'd32768,
               16'($urandom)};

    // Directed replies at the reset coefficient: all-ones payload with its checksum,
    // an empty reply, a short reply and a good reply followed by dropped bytes.
    push_frame(8'hFF, 1'b0, 1'b0, 0);
    push_item(ACT_END, 8'hFF);
    push_item(ACT_BYTE, 8'h00);
    push_item(ACT_END, 8'h00);
    push_marker(WAIT_IDLE, '0);
    push_frame(8'h00, 1'b0, 1'b0, 2);

    for (phase = 0; phase < 7; phase++) begin
      push_marker(WRITE_COEFF, coeffs[phase]);
      phase_end = item_total + (TARGET_ITEMS / 7);
      while (item_total < phase_end) begin
        push_random_reply();
        if ($urandom_range(39) == 0) push_marker(WAIT_IDLE, '0);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (pending.size() != 0 || settle < SETTLE_CYCLES);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && reply_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_HALF * 2 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule
